FILE: hdl/scpr_pkg.sv
// shared constants, register indexes and controller/datapath interface structs
package scpr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

  // replacement policy codes
  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_PERC = 1'b1;

  // reset value of the training threshold
  localparam logic [7:0] THRESH_RESET = 8'd18;

  // perceptron weight width and limits
  localparam int         WGT_W   = 8;
  localparam logic [7:0] WGT_MAX = 8'h7f;
  localparam logic [7:0] WGT_MIN = 8'h80;

  // shield values written on hit and on fill
  localparam logic [1:0] SHIELD_HIT  = 2'd3;
  localparam logic [1:0] SHIELD_FILL = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic clr;      // one step of the weight clearing pass
    logic accept;   // input transfer
    logic line_rd;  // read the set from the line store
    logic look;     // tag compare and first decision
    logic wrd;      // read the weight row of the scanned way
    logic wsc;      // score the scanned way and keep the best
    logic trd;      // read the weight row to be trained
    logic tsc;      // register the training score
    logic twr;      // train and write back the row
    logic commit;   // update lines, totals, history and result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_scan;
    logic need_train;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/set_assoc_cache_perceptron_replace.sv
// top level: set-associative cache with lru or perceptron replacement
//
//   channel  direction  ports                                        transfer
//   in       input      in_data_address, in_pc                       in_valid & !in_stall
//   out      output     out_hit, out_way, out_hits_so_far, out_misses out_valid & !out_stall
//   cfg      input      cfg_index, cfg_wdata                         cfg_we
//
// lru access or any fill into a free way: line read, lookup, then commit.
// perceptron hit: line read, lookup, weight row read, score, train and write back, commit.
// perceptron eviction: adds a victim scan that reads and scores the weight row of each way
//   in turn through the single weight table read port. one item is in flight at a time.
// after reset a clearing pass zeroes the weight table, one row a cycle
//   (2**floor(log2(TABLE_ROWS)) rows); in_stall stays high until it is done.
// a stalled result holds the block in its final state until the transfer.
module set_assoc_cache_perceptron_replace import scpr_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int BLOCK_BYTES  = 64,
  parameter int TABLE_ROWS   = 1024,
  parameter int HISTORY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_data_address,
  input  logic [31:0]           in_pc,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [1:0]            out_way,
  output logic [31:0]           out_hits_so_far,
  output logic [31:0]           out_misses_so_far
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  scpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (in_stall)
  );

  // storage and arithmetic
  scpr_dpath #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .TABLE_ROWS   (TABLE_ROWS),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_data_address   (in_data_address),
    .in_pc             (in_pc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_way           (out_way),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far)
  );

endmodule

FILE: hdl/scpr_ctrl.sv
// controller state machine sequencing lookup, scoring, training and commit
module scpr_ctrl import scpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LRD, ST_LOOK, ST_WRD, ST_WSC, ST_TRD, ST_TSC, ST_TWR, ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_LRD;
      ST_LRD:  state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (sts.need_scan) state_nxt = ST_WRD;
        else if (sts.need_train) state_nxt = ST_TRD;
        else state_nxt = ST_FIN;
      end
      ST_WRD:  state_nxt = ST_WSC;
      ST_WSC:  state_nxt = sts.scan_last ? ST_TRD : ST_WRD;
      ST_TRD:  state_nxt = ST_TSC;
      ST_TSC:  state_nxt = ST_TWR;
      ST_TWR:  state_nxt = ST_FIN;
      ST_FIN:  if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.clr     = (state_r == ST_CLR);
    cmd.accept  = (state_r == ST_IDLE) && in_valid;
    cmd.line_rd = (state_r == ST_LRD);
    cmd.look    = (state_r == ST_LOOK);
    cmd.wrd     = (state_r == ST_WRD);
    cmd.wsc     = (state_r == ST_WSC);
    cmd.trd     = (state_r == ST_TRD);
    cmd.tsc     = (state_r == ST_TSC);
    cmd.twr     = (state_r == ST_TWR);
    cmd.commit  = (state_r == ST_FIN) && sts.out_free;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: hdl/scpr_dpath.sv
// datapath: line store, weight table, scoring, training, totals and result register
module scpr_dpath import scpr_pkg::*; #(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int BLOCK_BYTES  = 64,
  parameter int TABLE_ROWS   = 1024,
  parameter int HISTORY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [31:0]           in_data_address,
  input  logic [31:0]           in_pc,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [1:0]            out_way,
  output logic [31:0]           out_hits_so_far,
  output logic [31:0]           out_misses_so_far
);

  localparam int OB    = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IB    = $clog2(SETS + 1) - 1;
  localparam int SGB   = $clog2(TABLE_ROWS + 1) - 1;
  localparam int SETW  = (IB > 0) ? IB : 1;
  localparam int NSETS = 1 << IB;
  localparam int WROWS = 1 << SGB;
  localparam int TAGW  = 32 - OB - IB;
  localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGEW  = WAYW;
  localparam int NW    = HISTORY_BITS + 1;
  localparam int SCW   = $clog2(NW * 128 + 1) + 2;
  localparam logic [31:0] SET_MASK = (32'd1 << IB) - 32'd1;
  localparam logic [31:0] SIG_MASK = (32'd1 << SGB) - 32'd1;
  localparam logic [AGEW-1:0] AGE_TOP = AGEW'(WAYS - 1);

  typedef struct packed {
    logic [TAGW-1:0] tag;
    logic [AGEW-1:0] age;
    logic [1:0]      shield;
    logic [SGB-1:0]  sig;
  } line_t;

  typedef logic [NW-1:0][WGT_W-1:0] row_t;

  // storage
  line_t [WAYS-1:0] lmem [NSETS];
  row_t             wmem [WROWS];
  logic [WAYS-1:0]  vld_r [NSETS];

  // configuration
  logic       policy_r;
  logic [7:0] thr_r;

  // item registers
  logic [TAGW-1:0]   tag_r;
  logic [SETW-1:0]   set_r;
  logic [SGB-1:0]    nsig_r;
  line_t [WAYS-1:0]  lraw_r;
  logic [WAYS-1:0]   svld_r;
  line_t [WAYS-1:0]  lv;
  logic              hit_r;
  logic [WAYW-1:0]   way_r;
  logic [WAYW-1:0]   cnt_r;
  row_t              wrow_r;
  logic [SGB-1:0]    twsig_r;
  logic signed [SCW-1:0] score_r;
  logic signed [SCW-1:0] bestu_r, besta_r;
  logic [WAYW-1:0]   vicu_r, vica_r;
  logic              ufound_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [31:0]       hit_tot_r, miss_tot_r;
  logic              out_valid_r, out_hit_r;
  logic [1:0]        out_way_r;
  logic [SGB-1:0]    clr_cnt_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_LRU;
      thr_r    <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY: policy_r <= cfg_wdata[0];
        REG_THRESH: thr_r    <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  // invalid ways read as zero
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lv[w] = svld_r[w] ? lraw_r[w] : '0;
    end
  end

  // tag compare, first free way and oldest way
  logic            hit_any, inv_any;
  logic [WAYW-1:0] hit_way, inv_way, lru_way;
  logic [AGEW-1:0] lru_age;
  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (svld_r[w] && (lv[w].tag == tag_r)) begin
        hit_any = 1'b1;
        hit_way = WAYW'(w);
      end
      if (!svld_r[w]) begin
        inv_any = 1'b1;
        inv_way = WAYW'(w);
      end
    end
    lru_age = lv[0].age;
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (lv[w].age > lru_age) begin
        lru_age = lv[w].age;
        lru_way = WAYW'(w);
      end
    end
  end

  // perceptron score of the registered row against the history
  logic [NW-1:0] xv;
  logic signed [SCW-1:0] score;
  assign xv = {hist_r, 1'b1};
  always_comb begin
    score = '0;
    for (int i = 0; i < NW; i++) begin
      if (xv[i]) score = score + SCW'(signed'(wrow_r[i]));
      else       score = score - SCW'(signed'(wrow_r[i]));
    end
  end

  // training decision and saturating update
  logic              dir_up, train_go;
  logic [SCW-1:0]    mag;
  row_t              new_row;
  logic [WGT_W:0]    tsum;
  assign dir_up = hit_r;
  assign mag    = score_r[SCW-1] ? SCW'(-score_r) : SCW'(score_r);
  assign train_go = ((!score_r[SCW-1]) != dir_up) || (mag <= SCW'(thr_r));
  always_comb begin
    tsum = '0;
    for (int i = 0; i < NW; i++) begin
      tsum = {wrow_r[i][WGT_W-1], wrow_r[i]} +
             ((xv[i] == dir_up) ? (WGT_W+1)'(1) : {(WGT_W+1){1'b1}});
      case (tsum[WGT_W:WGT_W-1])
        2'b01:   new_row[i] = WGT_MAX;
        2'b10:   new_row[i] = WGT_MIN;
        default: new_row[i] = tsum[WGT_W-1:0];
      endcase
    end
  end

  // scan compare, including the way scored this cycle
  logic              shu;
  logic              ufound_nxt;
  logic [WAYW-1:0]   vicu_nxt, vica_nxt;
  logic signed [SCW-1:0] bestu_nxt, besta_nxt;
  always_comb begin
    shu        = (lv[cnt_r].shield == 2'd0);
    ufound_nxt = ufound_r;
    vicu_nxt   = vicu_r;
    bestu_nxt  = bestu_r;
    vica_nxt   = vica_r;
    besta_nxt  = besta_r;
    if (shu && (!ufound_r || (score < bestu_r))) begin
      ufound_nxt = 1'b1;
      vicu_nxt   = cnt_r;
      bestu_nxt  = score;
    end
    if ((cnt_r == '0) || (score < besta_r)) begin
      vica_nxt  = cnt_r;
      besta_nxt = score;
    end
  end

  // weight row read address: scanned way, or the way to be trained
  logic [WAYW-1:0] ra_way;
  logic [SGB-1:0]  rd_sig;
  assign ra_way = cmd.trd ? way_r : cnt_r;
  assign rd_sig = lv[ra_way].sig;

  // weight table: clearing pass or training write, one read
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      wmem[clr_cnt_r] <= '0;
    end else if (cmd.twr && train_go) begin
      wmem[twsig_r] <= new_row;
    end
    if (cmd.wrd || cmd.trd) begin
      wrow_r  <= wmem[rd_sig];
      twsig_r <= rd_sig;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // line updates for the commit
  line_t [WAYS-1:0] nl;
  always_comb begin
    nl = lv;
    if (hit_r) begin
      if (policy_r == POL_LRU) begin
        for (int w = 0; w < WAYS; w++) begin
          if (svld_r[w] && (lv[w].age < lv[way_r].age)) begin
            nl[w].age = (lv[w].age >= AGE_TOP) ? AGE_TOP : lv[w].age + 1'b1;
          end
        end
        nl[way_r].age = '0;
      end else begin
        nl[way_r].shield = SHIELD_HIT;
        nl[way_r].sig    = nsig_r;
      end
    end else begin
      if (policy_r == POL_LRU) begin
        for (int w = 0; w < WAYS; w++) begin
          if (svld_r[w]) begin
            nl[w].age = (lv[w].age >= AGE_TOP) ? AGE_TOP : lv[w].age + 1'b1;
          end
        end
        nl[way_r].age = '0;
      end
      nl[way_r].tag    = tag_r;
      nl[way_r].sig    = nsig_r;
      nl[way_r].shield = SHIELD_FILL;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.line_rd) begin
      lraw_r <= lmem[set_r];
    end
    if (cmd.commit) begin
      lmem[set_r] <= nl;
    end
  end

  // line valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSETS; s++) begin
        vld_r[s] <= '0;
      end
    end else if (cmd.commit) begin
      vld_r[set_r][way_r] <= 1'b1;
    end
  end

  // item capture, lookup decision and scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r  <= TAGW'(in_data_address >> (OB + IB));
      set_r  <= SETW'((in_data_address >> OB) & SET_MASK);
      nsig_r <= SGB'((in_pc >> 2) & SIG_MASK);
    end
    if (cmd.line_rd) begin
      svld_r <= vld_r[set_r];
    end
    if (cmd.look) begin
      hit_r    <= hit_any;
      way_r    <= hit_any ? hit_way : (inv_any ? inv_way : lru_way);
      cnt_r    <= '0;
      ufound_r <= 1'b0;
    end
    if (cmd.wsc) begin
      cnt_r    <= cnt_r + 1'b1;
      ufound_r <= ufound_nxt;
      vicu_r   <= vicu_nxt;
      bestu_r  <= bestu_nxt;
      vica_r   <= vica_nxt;
      besta_r  <= besta_nxt;
      if (sts.scan_last) begin
        way_r <= ufound_nxt ? vicu_nxt : vica_nxt;
      end
    end
    if (cmd.tsc) begin
      score_r <= score;
    end
  end

  // history, totals and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      hit_tot_r   <= '0;
      miss_tot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (policy_r == POL_PERC) begin
          hist_r <= {hist_r[HISTORY_BITS-2 >= 0 ? HISTORY_BITS-2 : 0:0], hit_r} &
                    {HISTORY_BITS{1'b1}};
        end
        if (hit_r) hit_tot_r  <= hit_tot_r + 32'd1;
        else       miss_tot_r <= miss_tot_r + 32'd1;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= hit_r;
      out_way_r <= 2'(way_r);
    end
  end

  // status
  assign sts.clr_last   = (clr_cnt_r == '1);
  assign sts.need_scan  = !hit_any && !inv_any && (policy_r == POL_PERC);
  assign sts.need_train = hit_any && (policy_r == POL_PERC);
  assign sts.scan_last  = (cnt_r == WAYW'(WAYS - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_way           = out_way_r;
  assign out_hits_so_far   = hit_tot_r;
  assign out_misses_so_far = miss_tot_r;

endmodule

FILE: hdl/scpr_checker.sv
// port-level checks on the cache block, bound to the top level
module scpr_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [1:0]  out_way,
  input logic [31:0] out_hits_so_far,
  input logic [31:0] out_misses_so_far
);

  // reset empties the result register and blocks input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("result or input ready after reset");

  // one item at a time: an input transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // a new result appears only once the block is back to idle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while an item is in flight");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) && $stable(out_way)
      && $stable(out_hits_so_far) && $stable(out_misses_so_far))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_perceptron_replace scpr_props u_scpr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_hit           (out_hit),
  .out_way           (out_way),
  .out_hits_so_far   (out_hits_so_far),
  .out_misses_so_far (out_misses_so_far)
);

FILE: dv/scpr_checker.sv
// checker: watches the cache channels, predicts each lookup result and compares
module scpr_checker import scpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [31:0]           in_data_address,
  input  logic [31:0]           in_pc,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_hit,
  input  logic [1:0]            out_way,
  input  logic [31:0]           out_hits_so_far,
  input  logic [31:0]           out_misses_so_far,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_t;

  // predictor state
  logic              pol;
  logic [7:0]        thresh;
  logic              lv  [256];
  logic [19:0]       ltag[256];
  logic [1:0]        lage[256];
  logic [1:0]        lsh [256];
  logic [9:0]        lsig[256];
  logic signed [7:0] wrow[1024][9];
  logic [7:0]        hist;
  logic [31:0]       hcnt, mcnt;
  lookup_t           lookup_q[$];

  assign pending = lookup_q.size();

  function automatic int row_score(logic [9:0] sig);
    int s;
    s = int'(wrow[sig][0]);
    for (int i = 1; i <= 8; i++)
      s += hist[i-1] ? int'(wrow[sig][i]) : -int'(wrow[sig][i]);
    return s;
  endfunction

  function automatic logic signed [7:0] clip8(int v);
    return (v > 127) ? 8'sd127 : (v < -128) ? -8'sd128 : 8'(v);
  endfunction

  task automatic row_train(logic [9:0] sig, int d, int s);
    int mag;
    mag = s < 0 ? -s : s;
    if (((s >= 0) != (d == 1)) || mag <= int'(thresh)) begin
      wrow[sig][0] = clip8(wrow[sig][0] + d);
      for (int i = 1; i <= 8; i++)
        wrow[sig][i] = clip8(wrow[sig][i] + (hist[i-1] ? d : -d));
    end
  endtask

  function automatic logic [1:0] age_up(logic [1:0] a);
    return (a == 2'd3) ? 2'd3 : a + 2'd1;
  endfunction

  // work out one lookup and push the expected result
  task automatic predict_lookup(logic [31:0] addr, logic [31:0] pc);
    int base, victim, best, s, k;
    logic [19:0] tg;
    logic [1:0] cur;
    lookup_t r;
    base = int'(addr[11:6]) * 4;
    tg = addr[31:12];
    victim = -1;
    for (int i = 0; i < 4; i++) begin
      k = base + i;
      if (victim < 0 && lv[k] && ltag[k] == tg) begin
        victim = i;
        if (pol == POL_LRU) begin
          cur = lage[k];
          for (int j = 0; j < 4; j++)
            if (lv[base+j] && lage[base+j] < cur) lage[base+j] = age_up(lage[base+j]);
          lage[k] = 2'd0;
        end else begin
          s = row_score(lsig[k]);
          row_train(lsig[k], 1, s);
          hist = {hist[6:0], 1'b1};
          lsh[k] = SHIELD_HIT;
          lsig[k] = pc[11:2];
        end
      end
    end
    if (victim >= 0) begin
      hcnt++;
      r = '{1'b1, victim[1:0], hcnt, mcnt};
      lookup_q.push_back(r);
      return;
    end
    for (int i = 0; i < 4; i++)
      if (victim < 0 && !lv[base+i]) victim = i;
    if (victim < 0) begin
      if (pol == POL_LRU) begin
        best = -1;
        for (int i = 0; i < 4; i++)
          if (int'(lage[base+i]) > best) begin
            best = int'(lage[base+i]);
            victim = i;
          end
      end else begin
        best = 0;
        for (int i = 0; i < 4; i++) begin
          s = row_score(lsig[base+i]);
          if (lsh[base+i] == 0 && (victim < 0 || s < best)) begin
            best = s;
            victim = i;
          end
        end
        if (victim < 0)
          for (int i = 0; i < 4; i++) begin
            s = row_score(lsig[base+i]);
            if (victim < 0 || s < best) begin
              best = s;
              victim = i;
            end
          end
        row_train(lsig[base+victim], -1, best);
      end
    end
    if (pol == POL_LRU) begin
      for (int i = 0; i < 4; i++)
        if (lv[base+i]) lage[base+i] = age_up(lage[base+i]);
      lage[base+victim] = 2'd0;
    end else begin
      hist = {hist[6:0], 1'b0};
    end
    k = base + victim;
    lv[k] = 1'b1;
    ltag[k] = tg;
    lsig[k] = pc[11:2];
    lsh[k] = SHIELD_FILL;
    mcnt++;
    r = '{1'b0, victim[1:0], hcnt, mcnt};
    lookup_q.push_back(r);
  endtask

  // monitor: config writes, input transfers, result compare
  always @(posedge clk) begin
    lookup_t e;
    if (!rst_n) begin
      pol = POL_LRU;
      thresh = THRESH_RESET;
      for (int i = 0; i < 256; i++) begin
        lv[i] = 0; ltag[i] = 0; lage[i] = 0; lsh[i] = 0; lsig[i] = 0;
      end
      for (int i = 0; i < 1024; i++)
        for (int j = 0; j < 9; j++) wrow[i][j] = 0;
      hist = 0; hcnt = 0; mcnt = 0;
      fail_count = 0;
      lookup_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POLICY) pol = cfg_wdata[0];
        else if (cfg_index == REG_THRESH) thresh = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0d way=%0d", $time, out_hit, out_way);
          fail_count++;
        end else begin
          e = lookup_q.pop_front();
          if (out_hit !== e.hit || out_way !== e.way || out_hits_so_far !== e.hits ||
              out_misses_so_far !== e.misses) begin
            $display("%0t: mismatch expected hit=%0d way=%0d hits=%0d misses=%0d",
                     $time, e.hit, e.way, e.hits, e.misses);
            $display("%0t:          actual   hit=%0d way=%0d hits=%0d misses=%0d",
                     $time, out_hit, out_way, out_hits_so_far, out_misses_so_far);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_lookup(in_data_address, in_pc);
    end
  end

endmodule

FILE: dv/tb_set_assoc_cache_perceptron_replace.sv
// testbench top: stimulus, configuration phases and verdict for the cache
module tb_set_assoc_cache_perceptron_replace;
  import scpr_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 0;
  logic                  in_stall;
  logic [31:0]           in_data_address = '0;
  logic [31:0]           in_pc = '0;
  logic                  out_valid;
  logic                  out_stall = 0;
  logic                  out_hit;
  logic [1:0]            out_way;
  logic [31:0]           out_hits_so_far, out_misses_so_far;
  int                    fail_count, pending;
  int                    quiet_cycles = 0;
  int                    stall_mode = 0;

  localparam int QUIET_LIMIT = 20000;

  always #6 clk = ~clk;

  set_assoc_cache_perceptron_replace i_dut (.*);

  scpr_checker i_chk (.*);

  // receiver stall pattern, switching style now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 3));
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // watchdog on accepted transfers
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_access(logic [31:0] addr, logic [31:0] pc);
    in_valid <= 1'b1;
    in_data_address <= addr;
    in_pc <= pc;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic gap_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // idle the block, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // address biased to a few sets and tags so hits and evictions are common
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      a[11:6] = 6'($urandom_range(0, 3));
      a[31:12] = 20'($urandom_range(0, 7)) | (a[31] ? 20'h80000 : 20'h0);
    end
    return a;
  endfunction

  function automatic logic [31:0] pick_pc();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 3) != 0) p[11:2] = 10'($urandom_range(0, 7));
    return p;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(0, 3) == 0 ? 30 : int'($urandom_range(1, 8));
      for (int i = 0; i < burst && n > 0; i++, n--) send_access(pick_addr(), pick_pc());
      if ($urandom_range(0, 2) != 0) gap_cycles(int'($urandom_range(1, 12)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, fill, hits, lru evictions
    send_access(32'h0000_0000, 32'h0000_0000);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(32'h0000_0000, 32'h0000_0004);
    for (int t = 1; t <= 5; t++) send_access({20'(t), 6'd0, 6'd0}, 32'h10);
    send_access(32'h0000_1000, 32'h20);
    gap_cycles(3);
    // unknown register index is ignored
    write_reg(2'd3, 8'hFF);
    write_reg(REG_POLICY, 8'hFF);
    write_reg(REG_THRESH, 8'd0);
    // perceptron: shielded set then evictions
    for (int t = 0; t < 10; t++) send_access({20'(t), 6'd1, 6'd0}, {22'd0, 10'(t), 2'b0});
    send_access(32'h0000_0040, 32'h0);
    write_reg(REG_THRESH, 8'hFF);
    for (int t = 0; t < 6; t++) send_access({20'(t), 6'd1, 6'd0}, 32'hABC);
    // back to lru with ages left over from perceptron mode
    write_reg(REG_POLICY, {7'd0, POL_LRU});
    send_access(32'h0000_5040, 32'h0);
    send_access(32'h0000_0040, 32'h0);

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_POLICY, {7'd0, 1'(ph % 2 == 0 ? POL_PERC : POL_LRU)});
      case (ph % 4)
        0: write_reg(REG_THRESH, 8'd18);
        1: write_reg(REG_THRESH, 8'd0);
        2: write_reg(REG_THRESH, 8'd255);
        default: write_reg(REG_THRESH, 8'($urandom_range(0, 255)));
      endcase
      random_phase(200);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: set_assoc_cache_perceptron_replace.f
hdl/scpr_pkg.sv
hdl/scpr_ctrl.sv
hdl/scpr_dpath.sv
hdl/set_assoc_cache_perceptron_replace.sv
hdl/scpr_checker.sv
dv/scpr_checker.sv
dv/tb_set_assoc_cache_perceptron_replace.sv
